/* rtl/core/aip_pkg.sv */
// aip_pkg: shared types and constants for the ascii integer parser
package aip_pkg;

  // parse phase codes
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_PREFIX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;
  localparam logic [2:0] PH_FAIL   = 3'd6;

  // value type after reset (i32)
  localparam logic [2:0] VALUE_TYPE_RESET = 3'd4;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  // running parse state
  typedef struct packed {
    logic [2:0]  phase;
    logic        is_negative;
    logic        is_hex;
    logic [63:0] magnitude;
    logic        too_large;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{
    phase:       PH_LEAD,
    is_negative: 1'b0,
    is_hex:      1'b0,
    magnitude:   64'd0,
    too_large:   1'b0
  };

endpackage

/* rtl/core/ascii_integer_parser.sv */
// ascii_integer_parser: top level, character pipeline and range check
//
// Takes one character per beat on the in_ channel (in_ch, in_last) and gives
// one result beat on the out_ channel for each beat marked in_last:
// out_ok, out_value (type-sized two's complement, upper bytes zero) and
// out_byte_count. Leading and trailing whitespace, an optional sign, an
// optional 0x prefix, then decimal or hex digits are accepted.
// cfg_we/cfg_wdata set the target type (0 i8 .. 7 u64); the user must write
// it only while idle, as the block does not enforce this. Throughput: one
// character per cycle while in_ready is high. Three register stages: the input
// register, the state update into the parse and finish registers, and the
// range check into the result register; a result passes them in that order.
// Reset clears the parse state, all valid flags and sets the type to i32.
// When out_ready is low the result register holds; non-last characters still
// flow until a last character needs the held finish slot, then in_ready drops.
module ascii_integer_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [63:0] out_value,
  output logic [3:0]  out_byte_count
);

  logic [2:0]      value_type_r;
  logic            s1_v_r;
  logic [7:0]      s1_ch_r;
  logic            s1_last_r;
  aip_pkg::parse_t st_r;
  aip_pkg::parse_t st_nxt;
  logic            fin_v_r;
  logic            fin_ok_r;
  logic            fin_neg_r;
  logic [63:0]     fin_mag_r;
  logic            out_valid_r;
  logic            out_ok_r;
  logic [63:0]     out_value_r;
  logic [3:0]      out_bytes_r;
  logic            out_free;
  logic            fin_free;
  logic            s1_fire;
  logic            fin_fire;
  logic            in_fire;
  logic            sgn;
  logic [63:0]     mask;
  logic [63:0]     maxv;
  logic [3:0]      bytes;
  logic            chk_ok;
  logic [63:0]     chk_val;

  // handshake and stage advance
  assign out_free = !out_valid_r || out_ready;
  assign fin_free = !fin_v_r || out_free;
  assign fin_fire = fin_v_r && out_free;
  assign s1_fire  = s1_v_r && (!s1_last_r || fin_free);
  assign in_ready = !s1_v_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_type_r <= aip_pkg::VALUE_TYPE_RESET;
    end else if (cfg_we) begin
      value_type_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  // per-character state update
  aip_step u_step (
    .ch  (s1_ch_r),
    .cur (st_r),
    .nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= aip_pkg::PARSE_CLEAR;
    end else if (s1_fire) begin
      st_r <= s1_last_r ? aip_pkg::PARSE_CLEAR : st_nxt;
    end
  end

  // finish register holds the parse outcome of a completed string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      fin_v_r <= 1'b1;
    end else if (fin_fire) begin
      fin_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      fin_ok_r  <= ((st_nxt.phase == aip_pkg::PH_ZERO) ||
                    (st_nxt.phase == aip_pkg::PH_DIGITS) ||
                    (st_nxt.phase == aip_pkg::PH_TRAIL)) && !st_nxt.too_large;
      fin_neg_r <= st_nxt.is_negative;
      fin_mag_r <= st_nxt.magnitude;
    end
  end

  // type decode
  assign sgn = !value_type_r[0];
  always_comb begin
    case (value_type_r[2:1])
      2'd0:    begin bytes = 4'd1; mask = 64'h0000_0000_0000_00FF; end
      2'd1:    begin bytes = 4'd2; mask = 64'h0000_0000_0000_FFFF; end
      2'd2:    begin bytes = 4'd4; mask = 64'h0000_0000_FFFF_FFFF; end
      default: begin bytes = 4'd8; mask = 64'hFFFF_FFFF_FFFF_FFFF; end
    endcase
  end
  assign maxv = sgn ? (mask >> 1) : mask;

  // range check and two's complement
  always_comb begin
    chk_ok  = 1'b0;
    chk_val = fin_mag_r;
    if (fin_ok_r) begin
      if (fin_neg_r) begin
        chk_ok  = sgn && (fin_mag_r <= (maxv + 64'd1));
        chk_val = (64'd0 - fin_mag_r) & mask;
      end else begin
        chk_ok  = (fin_mag_r <= maxv);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_ok_r    <= chk_ok;
      out_value_r <= chk_ok ? chk_val : 64'd0;
      out_bytes_r <= chk_ok ? bytes : 4'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_value      = out_value_r;
  assign out_byte_count = out_bytes_r;

endmodule

/* rtl/core/aip_step.sv */
// aip_step: next parse state for one character
module aip_step (
  input  logic [7:0]     ch,
  input  aip_pkg::parse_t cur,
  output aip_pkg::parse_t nxt
);

  logic        is_space;
  logic        is_dec;
  logic        is_hexd;
  logic        dig_ok;
  logic [3:0]  dval;
  logic [67:0] scaled;
  logic [67:0] sum;
  aip_pkg::parse_t acc;

  // character classes
  assign is_space = (ch == aip_pkg::CH_SPACE) || (ch == aip_pkg::CH_TAB) ||
                    (ch == aip_pkg::CH_LF) || (ch == aip_pkg::CH_VT) ||
                    (ch == aip_pkg::CH_FF) || (ch == aip_pkg::CH_CR);
  assign is_dec   = (ch >= aip_pkg::CH_0) && (ch <= aip_pkg::CH_9);
  assign is_hexd  = ((ch >= aip_pkg::CH_LA) && (ch <= aip_pkg::CH_LF_HEX)) ||
                    ((ch >= aip_pkg::CH_UA) && (ch <= aip_pkg::CH_UF));
  assign dig_ok   = is_dec || (cur.is_hex && is_hexd);

  // digit value: letters map through their low nibble plus nine
  always_comb begin
    if (is_dec) begin
      dval = ch[3:0];
    end else begin
      dval = ch[3:0] + 4'd9;
    end
  end

  // shift-add by the base, overflow shows in the top nibble
  assign scaled = cur.is_hex ? {cur.magnitude, 4'b0000}
                             : ({4'b0000, cur.magnitude} << 3) +
                               ({4'b0000, cur.magnitude} << 1);
  assign sum    = scaled + {64'd0, dval};

  always_comb begin
    acc = cur;
    if (!cur.too_large) begin
      if (sum[67:64] != 4'd0) begin
        acc.too_large = 1'b1;
      end else begin
        acc.magnitude = sum[63:0];
      end
    end
  end

  // phase transitions
  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      aip_pkg::PH_LEAD, aip_pkg::PH_SIGNED: begin
        if ((cur.phase == aip_pkg::PH_LEAD) && is_space) begin
          nxt = cur;
        end else if ((cur.phase == aip_pkg::PH_LEAD) &&
                     ((ch == aip_pkg::CH_PLUS) || (ch == aip_pkg::CH_MINUS))) begin
          nxt.is_negative = (ch == aip_pkg::CH_MINUS);
          nxt.phase       = aip_pkg::PH_SIGNED;
        end else if (ch == aip_pkg::CH_0) begin
          nxt.phase = aip_pkg::PH_ZERO;
        end else if (is_dec) begin
          nxt       = acc;
          nxt.phase = aip_pkg::PH_DIGITS;
        end else begin
          nxt.phase = aip_pkg::PH_FAIL;
        end
      end
      aip_pkg::PH_ZERO: begin
        if ((ch == aip_pkg::CH_LX) || (ch == aip_pkg::CH_UX)) begin
          nxt.is_hex = 1'b1;
          nxt.phase  = aip_pkg::PH_PREFIX;
        end else if (is_space) begin
          nxt.phase = aip_pkg::PH_TRAIL;
        end else if (is_dec) begin
          nxt       = acc;
          nxt.phase = aip_pkg::PH_DIGITS;
        end else begin
          nxt.phase = aip_pkg::PH_FAIL;
        end
      end
      aip_pkg::PH_PREFIX, aip_pkg::PH_DIGITS: begin
        if (dig_ok) begin
          nxt       = acc;
          nxt.phase = aip_pkg::PH_DIGITS;
        end else if ((cur.phase == aip_pkg::PH_DIGITS) && is_space) begin
          nxt.phase = aip_pkg::PH_TRAIL;
        end else begin
          nxt.phase = aip_pkg::PH_FAIL;
        end
      end
      aip_pkg::PH_TRAIL: begin
        if (!is_space) begin
          nxt.phase = aip_pkg::PH_FAIL;
        end
      end
      default: begin
        nxt.phase = aip_pkg::PH_FAIL;
      end
    endcase
  end

endmodule
